[rtl/core/vsr_pkg.sv]
// Package with the transaction types, opcodes and scroll constants of the video scroll registers.
package vsr_pkg;

  localparam int unsigned OAM_BYTES = 256;
  localparam int unsigned OAM_AW    = $clog2(OAM_BYTES);

  localparam logic [4:0] OP_CTRL_WR    = 5'd0;
  localparam logic [4:0] OP_MASK_WR    = 5'd1;
  localparam logic [4:0] OP_STATUS_RD  = 5'd2;
  localparam logic [4:0] OP_OAM_ADDR   = 5'd3;
  localparam logic [4:0] OP_OAM_WR     = 5'd4;
  localparam logic [4:0] OP_OAM_RD     = 5'd5;
  localparam logic [4:0] OP_SCROLL_WR  = 5'd6;
  localparam logic [4:0] OP_ADDR_WR    = 5'd7;
  localparam logic [4:0] OP_DATA_WR    = 5'd8;
  localparam logic [4:0] OP_DATA_RD    = 5'd9;
  localparam logic [4:0] OP_COARSE_X   = 5'd10;
  localparam logic [4:0] OP_INC_Y      = 5'd11;
  localparam logic [4:0] OP_COPY_HORZ  = 5'd12;
  localparam logic [4:0] OP_COPY_VERT  = 5'd13;
  localparam logic [4:0] OP_VBLANK_SET = 5'd14;
  localparam logic [4:0] OP_VBLANK_CLR = 5'd15;
  localparam logic [4:0] OP_SPRITE0    = 5'd16;

  localparam logic [15:0] PALETTE_BASE = 16'h3f00;
  localparam logic [15:0] HORZ_MASK    = 16'h041f;
  localparam logic [15:0] VERT_MASK    = 16'h7be0;
  localparam logic [15:0] NT_X_BIT     = 16'h0400;
  localparam logic [15:0] NT_Y_BIT     = 16'h0800;
  localparam logic [15:0] FINE_Y_ONE   = 16'h1000;
  localparam logic [15:0] INC_ACROSS   = 16'h0001;
  localparam logic [15:0] INC_DOWN     = 16'h0020;
  localparam logic [4:0]  COARSE_Y_LAST_ROW = 5'd29;
  localparam logic [4:0]  MASK_RESET   = 5'h18;

  typedef struct packed {
    logic [4:0] opcode;
    logic [7:0] cpu_byte;
    logic [7:0] vram_read_data;
  } vsr_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] vram_addr;
    logic        vram_write_en;
    logic [7:0]  vram_write_data;
    logic        nmi_pulse;
    logic [15:0] scroll_address;
    logic [2:0]  fine_x_out;
    logic [7:0]  render_mode;
  } vsr_out_t;

  // Result of one step as the core hands it to the result register.
  typedef struct packed {
    vsr_out_t res;
    logic     oam_sel;
  } vsr_step_t;

endpackage

[rtl/core/vsr_ram.sv]
// Generic single-port-write, registered-read RAM.
module vsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/vsr_core.sv]
// Register state of the scroll unit and the single-pass logic that applies one transaction.
module vsr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  vsr_pkg::vsr_in_t in_item,
  output vsr_pkg::vsr_step_t step,
  output logic [7:0]       oam_rd_data
);
  import vsr_pkg::*;

  logic [15:0] cur_addr_r,   cur_addr_nxt;
  logic [14:0] tmp_addr_r,   tmp_addr_nxt;
  logic [2:0]  fine_x_r,     fine_x_nxt;
  logic        first_wr_r,   first_wr_nxt;
  logic [4:0]  ctrl_r,       ctrl_nxt;
  logic [4:0]  mask_r,       mask_nxt;
  logic        vblank_r,     vblank_nxt;
  logic        spr0_r,       spr0_nxt;
  logic [7:0]  rd_buf_r,     rd_buf_nxt;
  logic [OAM_AW-1:0] oam_ptr_r, oam_ptr_nxt;

  logic [7:0]  b;
  logic        show_bg;
  logic        show_both;
  logic [15:0] addr_step;
  logic [15:0] cur_advanced;
  logic [15:0] y_base;
  logic [4:0]  coarse_y;
  logic [15:0] tmp_wide;
  logic        oam_wr;
  vsr_out_t    res;

  assign b         = in_item.cpu_byte;
  assign show_bg   = mask_r[3];
  assign show_both = mask_r[3] & mask_r[4];
  assign addr_step = ctrl_r[0] ? INC_DOWN : INC_ACROSS;
  assign cur_advanced = cur_addr_r + addr_step;
  assign tmp_wide  = {1'b0, tmp_addr_r};
  assign y_base    = cur_addr_r & ~16'h7000;
  assign coarse_y  = cur_addr_r[9:5];

  always_comb begin
    cur_addr_nxt = cur_addr_r;
    tmp_addr_nxt = tmp_addr_r;
    fine_x_nxt   = fine_x_r;
    first_wr_nxt = first_wr_r;
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    vblank_nxt   = vblank_r;
    spr0_nxt     = spr0_r;
    rd_buf_nxt   = rd_buf_r;
    oam_ptr_nxt  = oam_ptr_r;
    oam_wr       = 1'b0;
    res          = '0;
    step.oam_sel = 1'b0;

    unique case (in_item.opcode)
      OP_CTRL_WR: begin
        ctrl_nxt = {b[7], b[5], b[4], b[3], b[2]};
        tmp_addr_nxt[11:10] = b[1:0];
      end
      OP_MASK_WR: begin
        mask_nxt = b[4:0];
      end
      OP_STATUS_RD: begin
        res.read_data = {vblank_r, spr0_r, 6'b0};
        vblank_nxt    = 1'b0;
        first_wr_nxt  = 1'b1;
      end
      OP_OAM_ADDR: begin
        oam_ptr_nxt = b[OAM_AW-1:0];
      end
      OP_OAM_WR: begin
        oam_wr      = 1'b1;
        oam_ptr_nxt = oam_ptr_r + 1'b1;
      end
      OP_OAM_RD: begin
        step.oam_sel = 1'b1;
      end
      OP_SCROLL_WR: begin
        if (first_wr_r) begin
          tmp_addr_nxt[4:0] = b[7:3];
          fine_x_nxt        = b[2:0];
        end else begin
          tmp_addr_nxt[14:12] = b[2:0];
          tmp_addr_nxt[9:5]   = b[7:3];
        end
        first_wr_nxt = ~first_wr_r;
      end
      OP_ADDR_WR: begin
        if (first_wr_r) begin
          tmp_addr_nxt = {1'b0, b[5:0], tmp_addr_r[7:0]};
        end else begin
          tmp_addr_nxt = {tmp_addr_r[14:8], b};
          cur_addr_nxt = {1'b0, tmp_addr_r[14:8], b};
        end
        first_wr_nxt = ~first_wr_r;
      end
      OP_DATA_WR: begin
        res.vram_addr       = cur_addr_r;
        res.vram_write_en   = 1'b1;
        res.vram_write_data = b;
        cur_addr_nxt        = cur_advanced;
      end
      OP_DATA_RD: begin
        res.vram_addr = cur_addr_r;
        // Palette space answers directly; everything below it goes through the buffer.
        if ({2'b00, cur_addr_r[13:0]} < PALETTE_BASE) begin
          res.read_data = rd_buf_r;
          rd_buf_nxt    = in_item.vram_read_data;
        end else begin
          res.read_data = in_item.vram_read_data;
        end
        cur_addr_nxt = cur_advanced;
      end
      OP_COARSE_X: begin
        if (show_bg) begin
          if (cur_addr_r[4:0] == 5'd31) begin
            cur_addr_nxt = {cur_addr_r[15:5], 5'd0} ^ NT_X_BIT;
          end else begin
            cur_addr_nxt = cur_addr_r + INC_ACROSS;
          end
        end
      end
      OP_INC_Y: begin
        if (show_bg) begin
          if (cur_addr_r[14:12] != 3'd7) begin
            cur_addr_nxt = cur_addr_r + FINE_Y_ONE;
          end else if (coarse_y == COARSE_Y_LAST_ROW) begin
            cur_addr_nxt = {y_base[15:10], 5'd0, y_base[4:0]} ^ NT_Y_BIT;
          end else if (coarse_y == 5'd31) begin
            cur_addr_nxt = {y_base[15:10], 5'd0, y_base[4:0]};
          end else begin
            cur_addr_nxt = {y_base[15:10], coarse_y + 5'd1, y_base[4:0]};
          end
        end
      end
      OP_COPY_HORZ: begin
        if (show_both) begin
          cur_addr_nxt = (cur_addr_r & ~HORZ_MASK) | (tmp_wide & HORZ_MASK);
        end
      end
      OP_COPY_VERT: begin
        if (show_both) begin
          cur_addr_nxt = (cur_addr_r & ~VERT_MASK) | (tmp_wide & VERT_MASK);
        end
      end
      OP_VBLANK_SET: begin
        vblank_nxt    = 1'b1;
        res.nmi_pulse = ctrl_r[4];
      end
      OP_VBLANK_CLR: begin
        vblank_nxt = 1'b0;
        spr0_nxt   = 1'b0;
      end
      OP_SPRITE0: begin
        if (show_both) begin
          spr0_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.scroll_address = cur_addr_nxt;
    res.fine_x_out     = fine_x_nxt;
    res.render_mode    = {mask_nxt[0], ~mask_nxt[2], ~mask_nxt[1], mask_nxt[4],
                          mask_nxt[3], ctrl_nxt[3], ctrl_nxt[1], ctrl_nxt[2]};
    step.res = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_addr_r <= '0;
      tmp_addr_r <= '0;
      fine_x_r   <= '0;
      first_wr_r <= 1'b1;
      ctrl_r     <= '0;
      mask_r     <= MASK_RESET;
      vblank_r   <= 1'b0;
      spr0_r     <= 1'b0;
      rd_buf_r   <= '0;
      oam_ptr_r  <= '0;
    end else if (accept) begin
      cur_addr_r <= cur_addr_nxt;
      tmp_addr_r <= tmp_addr_nxt;
      fine_x_r   <= fine_x_nxt;
      first_wr_r <= first_wr_nxt;
      ctrl_r     <= ctrl_nxt;
      mask_r     <= mask_nxt;
      vblank_r   <= vblank_nxt;
      spr0_r     <= spr0_nxt;
      rd_buf_r   <= rd_buf_nxt;
      oam_ptr_r  <= oam_ptr_nxt;
    end
  end

  vsr_ram #(
    .WIDTH (8),
    .DEPTH (OAM_BYTES)
  ) u_oam (
    .clk     (clk),
    .wr_en   (accept & oam_wr),
    .wr_addr (oam_ptr_r),
    .wr_data (b),
    .rd_en   (accept & step.oam_sel),
    .rd_addr (oam_ptr_r),
    .rd_data (oam_rd_data)
  );

endmodule

[rtl/core/video_scroll_register_interface.sv]
// Top level of the video scroll register interface with its result register.
// The block takes one transaction per clock while in_ready is high and answers each with
// exactly one result transaction in the following cycle: every opcode is applied to the
// scroll state (current address v, temporary address t, fine X, write toggle, control,
// mask and status flags) by a single pass of logic at the accepting edge, and the result
// lands in an output register. An OAM data read is served from the 256-byte sprite
// attribute memory, whose registered read port is clocked by the same accepting edge, so
// its byte arrives together with the rest of the result. Throughput is one transaction
// per cycle while out_ready is high; in_ready drops only while a finished result is held
// because out_ready is low. Reading an OAM entry that was never written returns an
// undefined byte.
module video_scroll_register_interface (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vsr_pkg::vsr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vsr_pkg::vsr_out_t out_data
);
  import vsr_pkg::*;

  logic      accept;
  vsr_step_t step;
  logic [7:0] oam_rd_data;

  // Result register: payload without reset, valid flag with reset.
  logic      out_valid_r, out_valid_nxt;
  vsr_out_t  res_r;
  logic      oam_sel_r;

  // A new transaction may enter whenever the result register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  vsr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_item     (in_data),
    .step        (step),
    .oam_rd_data (oam_rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r     <= step.res;
      oam_sel_r <= step.oam_sel;
    end
  end

  // The OAM byte is held in the memory's read register, which only loads on an accept,
  // so it stays stable while the result waits.
  always_comb begin
    out_data = res_r;
    if (oam_sel_r) begin
      out_data.read_data = oam_rd_data;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/vsr_checker.sv]
// Port-level checker for the video scroll register interface, bound to the top level.
module vsr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input vsr_pkg::vsr_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input vsr_pkg::vsr_out_t out_data
);
  import vsr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input blocked although the result stage can move");

  a_data_wr: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_DATA_WR
    |=> out_valid && out_data.vram_write_en)
    else $error("data write produced no video memory write");

  a_nmi_only_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode != OP_VBLANK_SET |=> !out_data.nmi_pulse)
    else $error("interrupt pulse outside vblank start");

endmodule

bind video_scroll_register_interface vsr_checker u_vsr_checker (.*);

[tb/sv/video_scroll_register_interface_tb.sv]
// Self-checking testbench for the video scroll register interface with a scroll-state shadow.
module video_scroll_register_interface_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vsr_pkg::*;

  // The highest opcode value and the first one that the block does not decode.
  localparam logic [4:0] OP_MAX          = 5'h1f;
  localparam logic [4:0] OP_FIRST_UNUSED = OP_SPRITE0 + 5'd1;

  // Control byte bit that selects the +32 data address step.
  localparam logic [7:0] CTRL_INC32 = 8'h04;

  // A watchdog fires after this many cycles without any transaction on either channel.
  localparam int STALL_LIMIT = 1000;

  // Data transactions after v has been carried up to 0xffff: the first +32 step wraps
  // the 16-bit address, and the ones after it leave the mirrored palette window.
  localparam int SWEEP_STEPS = 8;

  // Random transactions per phase.
  localparam int PHASE_ITEMS = 150;

  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES = 40;

  // Shadow of the register file. It applies every accepted input transaction to its own
  // copy of the scroll state and queues the result transaction the block must return.
  class scroll_shadow;
    logic [15:0] vaddr_cur;
    logic [14:0] vaddr_tmp;
    logic [2:0]  fine_scroll_x;
    logic        toggle_first;
    logic [4:0]  ctrl_r;
    logic [4:0]  mask_r;
    logic        in_vblank;
    logic        hit_sprite0;
    logic [7:0]  data_buffer;
    logic [7:0]  oam_ptr;
    logic [7:0]  oam_mem [OAM_BYTES];
    bit   [OAM_BYTES-1:0] oam_valid;
    vsr_out_t    pending_replies [$];
    int          mismatches;

    function new();
      vaddr_cur     = '0;
      vaddr_tmp     = '0;
      fine_scroll_x = '0;
      toggle_first  = 1'b1;
      ctrl_r        = '0;
      mask_r        = MASK_RESET;
      in_vblank     = 1'b0;
      hit_sprite0   = 1'b0;
      data_buffer   = '0;
      oam_ptr       = '0;
      oam_valid     = '0;
      mismatches    = 0;
    endfunction

    function bit oam_entry_written();
      return oam_valid[oam_ptr];
    endfunction

    function int waiting();
      return pending_replies.size();
    endfunction

    function void step_data_addr();
      vaddr_cur = vaddr_cur + (ctrl_r[0] ? INC_DOWN : INC_ACROSS);
    endfunction

    function void note_request(vsr_in_t req);
      vsr_out_t    res;
      logic [15:0] v;
      logic [4:0]  y;
      logic [7:0]  b;
      logic        show_bg;
      logic        show_both;
      res       = '0;
      b         = req.cpu_byte;
      show_bg   = mask_r[3];
      show_both = mask_r[3] && mask_r[4];
      case (req.opcode)
        OP_CTRL_WR: begin
          ctrl_r            = {b[7], b[5], b[4], b[3], b[2]};
          vaddr_tmp[11:10]  = b[1:0];
        end
        OP_MASK_WR: begin
          mask_r = b[4:0];
        end
        OP_STATUS_RD: begin
          res.read_data = {in_vblank, hit_sprite0, 6'b0};
          in_vblank     = 1'b0;
          toggle_first  = 1'b1;
        end
        OP_OAM_ADDR: begin
          oam_ptr = b;
        end
        OP_OAM_WR: begin
          oam_mem[oam_ptr]   = b;
          oam_valid[oam_ptr] = 1'b1;
          oam_ptr            = oam_ptr + 8'd1;
        end
        OP_OAM_RD: begin
          res.read_data = oam_mem[oam_ptr];
        end
        OP_SCROLL_WR: begin
          if (toggle_first) begin
            vaddr_tmp[4:0] = b[7:3];
            fine_scroll_x  = b[2:0];
          end else begin
            vaddr_tmp[14:12] = b[2:0];
            vaddr_tmp[9:5]   = b[7:3];
          end
          toggle_first = !toggle_first;
        end
        OP_ADDR_WR: begin
          if (toggle_first) begin
            vaddr_tmp[13:8] = b[5:0];
            vaddr_tmp[14]   = 1'b0;
          end else begin
            vaddr_tmp[7:0] = b;
            vaddr_cur      = {1'b0, vaddr_tmp};
          end
          toggle_first = !toggle_first;
        end
        OP_DATA_WR: begin
          res.vram_addr       = vaddr_cur;
          res.vram_write_en   = 1'b1;
          res.vram_write_data = b;
          step_data_addr();
        end
        OP_DATA_RD: begin
          res.vram_addr = vaddr_cur;
          // Below the palette the read is buffered by one access; palette reads are direct.
          if (vaddr_cur[13:0] < PALETTE_BASE[13:0]) begin
            res.read_data = data_buffer;
            data_buffer   = req.vram_read_data;
          end else begin
            res.read_data = req.vram_read_data;
          end
          step_data_addr();
        end
        OP_COARSE_X: begin
          if (show_bg) begin
            if (vaddr_cur[4:0] == 5'h1f) begin
              vaddr_cur[4:0] = 5'h00;
              vaddr_cur      = vaddr_cur ^ NT_X_BIT;
            end else begin
              vaddr_cur = vaddr_cur + INC_ACROSS;
            end
          end
        end
        OP_INC_Y: begin
          if (show_bg) begin
            if (vaddr_cur[14:12] != 3'b111) begin
              vaddr_cur = vaddr_cur + FINE_Y_ONE;
            end else begin
              v        = vaddr_cur;
              v[14:12] = 3'b000;
              y        = v[9:5];
              if (y == COARSE_Y_LAST_ROW) begin
                y = 5'd0;
                v = v ^ NT_Y_BIT;
              end else if (y == 5'h1f) begin
                y = 5'd0;
              end else begin
                y = y + 5'd1;
              end
              v[9:5]    = y;
              vaddr_cur = v;
            end
          end
        end
        OP_COPY_HORZ: begin
          if (show_both) begin
            vaddr_cur = (vaddr_cur & ~HORZ_MASK) | ({1'b0, vaddr_tmp} & HORZ_MASK);
          end
        end
        OP_COPY_VERT: begin
          if (show_both) begin
            vaddr_cur = (vaddr_cur & ~VERT_MASK) | ({1'b0, vaddr_tmp} & VERT_MASK);
          end
        end
        OP_VBLANK_SET: begin
          in_vblank     = 1'b1;
          res.nmi_pulse = ctrl_r[4];
        end
        OP_VBLANK_CLR: begin
          in_vblank   = 1'b0;
          hit_sprite0 = 1'b0;
        end
        OP_SPRITE0: begin
          if (show_both) begin
            hit_sprite0 = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.scroll_address = vaddr_cur;
      res.fine_x_out     = fine_scroll_x;
      res.render_mode    = {mask_r[0], ~mask_r[2], ~mask_r[1], mask_r[4], mask_r[3],
                            ctrl_r[3], ctrl_r[1], ctrl_r[2]};
      pending_replies = {pending_replies, res};
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(vsr_out_t got);
      vsr_out_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = pending_replies.pop_front();
      compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
      compare_field("vram_addr", want.vram_addr, got.vram_addr);
      compare_field("vram_write_en", 16'(want.vram_write_en), 16'(got.vram_write_en));
      compare_field("vram_write_data", 16'(want.vram_write_data),
                    16'(got.vram_write_data));
      compare_field("nmi_pulse", 16'(want.nmi_pulse), 16'(got.nmi_pulse));
      compare_field("scroll_address", want.scroll_address, got.scroll_address);
      compare_field("fine_x_out", 16'(want.fine_x_out), 16'(got.fine_x_out));
      compare_field("render_mode", 16'(want.render_mode), 16'(got.render_mode));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  vsr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  vsr_out_t out_data;

  scroll_shadow shadow;

  // Idling odds in percent per cycle, and the remaining cycles of a forced receiver hold-off.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int accepted_items;

  video_scroll_register_interface uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Offers one input transaction. Inputs change only at the falling edge, and the
  // handshake is sampled at the rising edge. Valid stays high across back-to-back
  // transactions; it drops only for a random idle gap in front of a transaction.
  // An OAM read of an entry that was never written is turned into an OAM write, so
  // the undefined contents of the sprite memory are never observed.
  task automatic send_item(vsr_in_t req);
    int gap;
    gap = 0;
    if (req.opcode == OP_OAM_RD && !shadow.oam_entry_written()) begin
      req.opcode = OP_OAM_WR;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    shadow.note_request(req);
    accepted_items++;
    @(negedge clk);
  endtask

  // Sends one opcode with a CPU byte; the video memory byte is always random.
  task automatic send_op(logic [4:0] op, logic [7:0] b);
    vsr_in_t req;
    req.opcode         = op;
    req.cpu_byte       = b;
    req.vram_read_data = 8'($urandom);
    send_item(req);
  endtask

  // One random burst. Most bursts are well-formed register sequences (scroll and
  // address pairs, address then data accesses, OAM address then writes then a read
  // back, runs of render events with the show flags mostly on); a few are single
  // random opcodes, unused opcodes among them.
  task automatic send_random_burst();
    int         kind;
    int         n;
    logic [7:0] hi;
    logic [7:0] b;
    logic [7:0] spot;
    logic [4:0] op;
    kind = $urandom_range(99);
    if (kind < 20) begin
      if ($urandom_range(3) == 0) begin
        send_op(OP_STATUS_RD, 8'($urandom));
      end
      send_op(OP_SCROLL_WR, 8'($urandom));
      send_op(OP_SCROLL_WR, 8'($urandom));
    end else if (kind < 35) begin
      // Point v into the palette window often, so both read paths are taken.
      case ($urandom_range(3))
        0:       hi = PALETTE_BASE[15:8];
        1:       hi = 8'($urandom) | PALETTE_BASE[15:8];
        default: hi = 8'($urandom);
      endcase
      if ($urandom_range(3) == 0) begin
        send_op(OP_STATUS_RD, 8'($urandom));
      end
      send_op(OP_ADDR_WR, hi);
      send_op(OP_ADDR_WR, 8'($urandom));
      n = $urandom_range(4, 1);
      repeat (n) begin
        send_op($urandom_range(1) ? OP_DATA_RD : OP_DATA_WR, 8'($urandom));
      end
    end else if (kind < 60) begin
      n = $urandom_range(8, 1);
      repeat (n) begin
        case ($urandom_range(4))
          0:       op = OP_COARSE_X;
          1:       op = OP_INC_Y;
          2:       op = OP_COPY_HORZ;
          3:       op = OP_COPY_VERT;
          default: op = OP_SPRITE0;
        endcase
        send_op(op, 8'($urandom));
      end
    end else if (kind < 68) begin
      b = 8'($urandom);
      if ($urandom_range(4) != 0) begin
        b = b | {3'b000, MASK_RESET};
      end
      send_op(OP_MASK_WR, b);
    end else if (kind < 74) begin
      send_op(OP_CTRL_WR, 8'($urandom));
    end else if (kind < 82) begin
      case ($urandom_range(2))
        0:       op = OP_VBLANK_SET;
        1:       op = OP_VBLANK_CLR;
        default: op = OP_STATUS_RD;
      endcase
      send_op(op, 8'($urandom));
    end else if (kind < 92) begin
      spot = 8'($urandom);
      send_op(OP_OAM_ADDR, spot);
      n = $urandom_range(3);
      repeat (n) begin
        send_op(OP_OAM_WR, 8'($urandom));
      end
      if ($urandom_range(1) == 0) begin
        send_op(OP_OAM_ADDR, spot);
      end
      send_op(OP_OAM_RD, 8'($urandom));
    end else if (kind < 97) begin
      send_op(5'($urandom_range(OP_MAX)), 8'($urandom));
    end else begin
      send_op(5'($urandom_range(OP_MAX, OP_FIRST_UNUSED)), 8'($urandom));
    end
  endtask

  // Every result transaction is checked at the rising edge where it is accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      shadow.check_result(out_data);
    end
  end

  // Receiver: random back-pressure at the falling edge, or a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved a transaction for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("video_scroll_register_interface_tb: errors");
    $finish;
  end

  // Main sequence: reset, directed cases, then three phases of random bursts, two with idling.
  initial begin
    int target;
    int hold_at;
    bit held;
    shadow         = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    accepted_items = 0;
    send_idle_pct  = 17;
    recv_idle_pct  = 56;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Status flags, the interrupt pulse and sprite-0 with the reset mask.
    send_op(OP_STATUS_RD, 8'h00);
    send_op(OP_CTRL_WR, 8'hff);
    send_op(OP_VBLANK_SET, 8'h00);
    send_op(OP_SPRITE0, 8'h00);
    send_op(OP_STATUS_RD, 8'h00);
    // All-ones scroll, copied down to v: fine Y of seven with coarse Y of 31 wraps to 0
    // without a nametable flip.
    send_op(OP_SCROLL_WR, 8'hff);
    send_op(OP_SCROLL_WR, 8'hff);
    send_op(OP_COPY_VERT, 8'h00);
    send_op(OP_INC_Y, 8'h00);
    // Address write with the upper bits masked off; v lands inside the palette, which
    // is read directly, then the coarse X wrap leaves it for a buffered read.
    send_op(OP_ADDR_WR, 8'hff);
    send_op(OP_ADDR_WR, 8'h1f);
    send_op(OP_DATA_RD, 8'h00);
    send_op(OP_DATA_WR, 8'hff);
    send_op(OP_COARSE_X, 8'h00);
    send_op(OP_DATA_RD, 8'h00);
    // Coarse Y of 29 with fine Y of seven flips the vertical nametable.
    send_op(OP_SCROLL_WR, 8'h00);
    send_op(OP_SCROLL_WR, 8'hef);
    send_op(OP_COPY_VERT, 8'h00);
    send_op(OP_INC_Y, 8'h00);
    // The OAM pointer wraps from the last entry to the first.
    send_op(OP_OAM_ADDR, 8'hff);
    send_op(OP_OAM_WR, 8'h80);
    send_op(OP_OAM_WR, 8'h01);
    send_op(OP_OAM_ADDR, 8'hff);
    send_op(OP_OAM_RD, 8'h00);
    // Render gating: background only, then nothing shown.
    send_op(OP_MASK_WR, 8'h08);
    send_op(OP_COPY_HORZ, 8'h00);
    send_op(OP_SPRITE0, 8'h00);
    send_op(OP_MASK_WR, 8'h00);
    send_op(OP_COARSE_X, 8'h00);
    send_op(OP_MAX, 8'hff);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Carry v to the top of the 16-bit range: v starts at 0x3fe0, four fine Y
          // steps bring it to 0x7fe0, one +32 data access sets the top bit, and both
          // copies from an all-ones t fill in the rest. The following +32 data
          // accesses wrap v and move from the mirrored palette to buffered reads.
          send_op(OP_STATUS_RD, 8'($urandom));
          send_op(OP_MASK_WR, {3'b000, MASK_RESET});
          send_op(OP_CTRL_WR, 8'($urandom) | CTRL_INC32);
          send_op(OP_ADDR_WR, PALETTE_BASE[15:8]);
          send_op(OP_ADDR_WR, 8'he0);
          repeat (4) begin
            send_op(OP_INC_Y, 8'h00);
          end
          send_op($urandom_range(1) ? OP_DATA_RD : OP_DATA_WR, 8'($urandom));
          send_op(OP_SCROLL_WR, 8'hff);
          send_op(OP_SCROLL_WR, 8'hff);
          send_op(OP_COPY_VERT, 8'h00);
          send_op(OP_COPY_HORZ, 8'h00);
          repeat (SWEEP_STEPS) begin
            send_op($urandom_range(1) ? OP_DATA_RD : OP_DATA_WR, 8'($urandom));
          end
        end
      endcase
      target  = accepted_items + PHASE_ITEMS;
      hold_at = accepted_items + PHASE_ITEMS / 2;
      held    = 0;
      while (accepted_items < target) begin
        // In the two idling phases the receiver stops once for a long stretch while
        // the sender keeps offering, so the result register fills and in_ready drops.
        if (phase < 2 && !held && accepted_items >= hold_at) begin
          hold_left = HOLD_CYCLES;
          held      = 1;
        end
        send_random_burst();
      end
    end
    in_valid <= 1'b0;

    while (shadow.waiting() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.waiting() == 0) begin
      $display("video_scroll_register_interface_tb: clean");
    end else begin
      $display("video_scroll_register_interface_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/vsr_pkg.sv
rtl/core/vsr_ram.sv
rtl/core/vsr_core.sv
rtl/core/video_scroll_register_interface.sv
rtl/core/vsr_checker.sv
tb/sv/video_scroll_register_interface_tb.sv
